// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/mbrm_pkg.sv =====
// Shared types, constants and the CRC-16 step for the Modbus RTU read master.
// No dependencies.
package mbrm_pkg;

	localparam int MAX_FRAME_DEF = 16;
	localparam int MIN_FRAME     = 7;
	localparam int FIFO_DEPTH    = 4;
	localparam int APB_AW        = 3;

	localparam logic [7:0]  FUNC_READ    = 8'd3;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [7:0]  SLAVE_RESET  = 8'd1;
	localparam logic [7:0]  REG_COUNT_LO = 8'd2;

	typedef enum logic {
		REQ_ISSUE = 1'b0,
		REQ_RX    = 1'b1
	} req_kind_t;

	typedef enum logic {
		KIND_TX      = 1'b0,
		KIND_VERDICT = 1'b1
	} out_kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERSIZE = 3'd1,
		ST_CRC      = 3'd2,
		ST_SHORT    = 3'd3,
		ST_BAD_FUNC = 3'd4,
		ST_NONE     = 3'd5
	} status_t;

	typedef struct packed {
		out_kind_t   kind;
		status_t     status;
		logic [7:0]  tag;
		logic [31:0] value;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_slot_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/mbrm_front.sv =====
// Front end: accepts items, tracks the receive frame and pending request,
// and pushes request and verdict entries. Depends on mbrm_pkg.
`include "assert_macros.svh"
module mbrm_front #(
	parameter int MAX_FRAME = mbrm_pkg::MAX_FRAME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [7:0]        reg_number,
	input  logic [7:0]        rx_byte,
	input  logic              rx_last,
	input  logic              q_full,
	output mbrm_pkg::q_slot_t q_push
);
	import mbrm_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 2);

	logic [CNT_W-1:0] cnt_q, cnt_nx;
	logic [15:0]      crc_q, crc_nx;
	logic [7:0]       func_q, func_nx;
	logic [31:0]      val_q, val_nx;
	logic             pend_q;
	logic [7:0]       pend_reg_q;
	logic             acc, is_req;
	status_t          verdict;

	assign is_req   = (req_kind_t'(req_type) == REQ_ISSUE);
	// response bytes that end no frame push nothing, so let them in when full
	assign in_ready = !q_full || (!is_req && !rx_last);
	assign acc      = in_valid && in_ready;

	assign cnt_nx  = (cnt_q < CNT_W'(MAX_FRAME + 1)) ? cnt_q + CNT_W'(1) : cnt_q;
	assign crc_nx  = crc_feed(crc_q, rx_byte);
	assign func_nx = (cnt_q == CNT_W'(1)) ? rx_byte : func_q;

	always_comb begin
		val_nx = val_q;
		priority if (cnt_q == CNT_W'(3)) begin
			val_nx[15:8] = rx_byte;
		end else if (cnt_q == CNT_W'(4)) begin
			val_nx[7:0] = rx_byte;
		end else if (cnt_q == CNT_W'(5)) begin
			val_nx[31:24] = rx_byte;
		end else if (cnt_q == CNT_W'(6)) begin
			val_nx[23:16] = rx_byte;
		end else begin
			val_nx = val_q;
		end
	end

	always_comb begin
		priority if (cnt_nx > CNT_W'(MAX_FRAME)) begin
			verdict = ST_OVERSIZE;
		end else if (cnt_nx < CNT_W'(2) || crc_nx != 16'h0000) begin
			verdict = ST_CRC;
		end else if (cnt_nx < CNT_W'(MIN_FRAME)) begin
			verdict = ST_SHORT;
		end else if (func_nx != FUNC_READ) begin
			verdict = ST_BAD_FUNC;
		end else if (!pend_q) begin
			verdict = ST_NONE;
		end else begin
			verdict = ST_OK;
		end
	end

	always_comb begin
		q_push.valid = acc && (is_req || rx_last);
		if (is_req) begin
			q_push.entry.kind   = KIND_TX;
			q_push.entry.status = ST_OK;
			q_push.entry.tag    = reg_number;
			q_push.entry.value  = 32'd0;
		end else begin
			q_push.entry.kind   = KIND_VERDICT;
			q_push.entry.status = verdict;
			q_push.entry.tag    = pend_reg_q;
			q_push.entry.value  = (verdict == ST_OK) ? val_nx : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			crc_q      <= CRC_INIT;
			func_q     <= 8'd0;
			val_q      <= 32'd0;
			pend_q     <= 1'b0;
			pend_reg_q <= 8'd0;
		end else if (acc) begin
			if (is_req) begin
				pend_q     <= 1'b1;
				pend_reg_q <= reg_number;
			end else if (rx_last) begin
				// drop frame state; a CRC-valid frame that is not oversize answers the request
				cnt_q  <= '0;
				crc_q  <= CRC_INIT;
				func_q <= 8'd0;
				val_q  <= 32'd0;
				if (verdict != ST_OVERSIZE && verdict != ST_CRC) begin
					pend_q <= 1'b0;
				end
			end else begin
				cnt_q  <= cnt_nx;
				crc_q  <= crc_nx;
				func_q <= func_nx;
				val_q  <= val_nx;
			end
		end
	end

	`ASSERT_CLK(a_oversize_keeps_pend, (q_push.valid && q_push.entry.status == ST_OVERSIZE && q_push.entry.kind == KIND_VERDICT) |=> (pend_q == $past(pend_q)), "oversize frame changed pending")
	`ASSERT_NEVER(a_cnt_sat, cnt_q > CNT_W'(MAX_FRAME + 1), "byte count past saturation")

endmodule

// ===== hw/rtl/mbrm_fifo.sv =====
// Short queue between front and back ends.
// Depends on mbrm_pkg.
`include "assert_macros.svh"
module mbrm_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  mbrm_pkg::q_slot_t push,
	output logic              full,
	output mbrm_pkg::q_slot_t head,
	input  logic              pop
);
	import mbrm_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	q_entry_t        mem_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = (count_q == CW'(FIFO_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid && !full) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid && !full) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push.valid && !full) - CW'(do_pop);
		end
	end

	`ASSERT_NEVER(a_push_full, push.valid && full, "push into full queue")
	`ASSERT_NEVER(a_count_range, count_q > CW'(FIFO_DEPTH), "queue count out of range")

endmodule

// ===== hw/rtl/mbrm_back.sv =====
// Back end: expands request entries into eight frame bytes with CRC and
// passes verdicts, through one output register. Depends on mbrm_pkg.
`include "assert_macros.svh"
module mbrm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        slave_address,
	input  mbrm_pkg::q_slot_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_kind,
	output logic [7:0]        tx_byte,
	output logic              run_last,
	output logic [2:0]        status,
	output logic [7:0]        reg_tag,
	output logic [31:0]       value_bits
);
	import mbrm_pkg::*;

	logic        out_valid_q;
	logic        kind_q, last_q;
	logic [7:0]  tx_q, tag_q;
	logic [2:0]  status_q;
	logic [31:0] value_q;
	logic [2:0]  idx_q;
	logic [15:0] crc_q, crc_seed;
	logic [7:0]  frame_byte;
	logic        load, is_tx, seq_end;

	assign load    = head.valid && (!out_valid_q || out_ready);
	assign is_tx   = (head.entry.kind == KIND_TX);
	assign seq_end = (idx_q == 3'd7);
	assign pop     = load && (!is_tx || seq_end);

	assign crc_seed = (idx_q == 3'd0) ? CRC_INIT : crc_q;

	always_comb begin
		unique case (idx_q)
			3'd0:    frame_byte = slave_address;
			3'd1:    frame_byte = FUNC_READ;
			3'd2:    frame_byte = 8'd0;
			3'd3:    frame_byte = head.entry.tag - 8'd1;
			3'd4:    frame_byte = 8'd0;
			3'd5:    frame_byte = REG_COUNT_LO;
			3'd6:    frame_byte = crc_q[7:0];
			default: frame_byte = crc_q[15:8];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= head.entry.kind;
			tag_q   <= head.entry.tag;
			status_q <= head.entry.status;
			value_q <= head.entry.value;
			tx_q    <= is_tx ? frame_byte : 8'd0;
			last_q  <= !is_tx || seq_end;
			if (is_tx && idx_q < 3'd6) begin
				crc_q <= crc_feed(crc_seed, frame_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load && is_tx) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = kind_q;
	assign tx_byte    = tx_q;
	assign run_last   = last_q;
	assign status     = status_q;
	assign reg_tag    = tag_q;
	assign value_bits = value_q;

	`ASSERT_CLK(a_seq_wrap, (load && is_tx && seq_end) |=> (idx_q == 3'd0), "request sequence did not wrap")
	`ASSERT_NEVER(a_verdict_mid_seq, load && !is_tx && idx_q != 3'd0, "verdict inside request sequence")

endmodule

// ===== hw/rtl/modbus_rtu_register_read_master.sv =====
// Top level of the Modbus RTU read-holding-registers master.
// Depends on mbrm_pkg, mbrm_front, mbrm_fifo and mbrm_back.
//
// Takes one input item per cycle while in_ready is high. A response byte is
// checked against the streaming CRC-16 in the cycle it is accepted. The
// frame's last byte queues one verdict at the accepting edge. The verdict
// loads from the queue into the output register once the output is free. A
// request item queues one entry that the output sequencer turns into eight
// request bytes, one per cycle while the output is taken.
// A four-entry queue sits between intake and output; when it is full, request
// items and frame-ending bytes wait while other response bytes still flow.
// slave_address sits at byte address 0 of the APB port and resets to 1.
module modbus_rtu_register_read_master #(
	parameter int MAX_FRAME = mbrm_pkg::MAX_FRAME_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbrm_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [7:0]                  reg_number,
	input  logic [7:0]                  rx_byte,
	input  logic                        rx_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        out_kind,
	output logic [7:0]                  tx_byte,
	output logic                        run_last,
	output logic [2:0]                  status,
	output logic [7:0]                  reg_tag,
	output logic [31:0]                 value_bits
);
	import mbrm_pkg::*;

	logic [7:0] slave_q;
	logic       sel_slave;
	q_slot_t    q_push, q_head;
	logic       q_full, q_pop;

	assign pready    = 1'b1;
	assign sel_slave = !paddr[APB_AW-1];
	assign prdata    = sel_slave ? {24'd0, slave_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= SLAVE_RESET;
		end else if (psel && penable && pwrite && pready && sel_slave) begin
			slave_q <= pwdata[7:0];
		end
	end

	mbrm_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.reg_number(reg_number),
		.rx_byte   (rx_byte),
		.rx_last   (rx_last),
		.q_full    (q_full),
		.q_push    (q_push)
	);

	mbrm_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.full  (q_full),
		.head  (q_head),
		.pop   (q_pop)
	);

	mbrm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.slave_address(slave_q),
		.head         (q_head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_kind     (out_kind),
		.tx_byte      (tx_byte),
		.run_last     (run_last),
		.status       (status),
		.reg_tag      (reg_tag),
		.value_bits   (value_bits)
	);

endmodule

// ===== test/tb_modbus_rtu_register_read_master.sv =====
// Testbench for the Modbus RTU register read master: request encoding, CRC-16 and reply verdicts.
// Depends on mbrm_pkg and modbus_rtu_register_read_master; predicts every output in the bench.
`timescale 1ns / 100ps

module tb_modbus_rtu_register_read_master;
	import mbrm_pkg::*;

	localparam int FRAME_MAX = MAX_FRAME_DEF;
	localparam logic [2:0] REG_SLAVE_ADDR = 3'd0;
	localparam int STALL_MAX = 13;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		out_kind_t   kind;
		logic [7:0]  tx;
		logic        last;
		status_t     st;
		logic [7:0]  tag;
		logic [31:0] val;
	} master_out_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [7:0]  reg_number;
	logic [7:0]  rx_byte;
	logic        rx_last;
	logic        out_valid;
	logic        out_ready;
	logic        out_kind;
	logic [7:0]  tx_byte;
	logic        run_last;
	logic [2:0]  status;
	logic [7:0]  reg_tag;
	logic [31:0] value_bits;

	// predicted master state
	logic [7:0]  slave_addr = SLAVE_RESET;
	logic [15:0] rx_crc     = CRC_INIT;
	logic [4:0]  rx_count   = '0;
	logic [7:0]  rx_func    = '0;
	logic [31:0] rx_word    = '0;
	logic        req_open   = 1'b0;
	logic [7:0]  req_reg    = '0;

	master_out_t due_outputs[$];
	master_out_t got_want;
	logic [7:0]  frame_buf[$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          gap_next = 0;
	bit          in_held = 0;
	bit          calm = 0;

	modbus_rtu_register_read_master dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.reg_number(reg_number), .rx_byte(rx_byte), .rx_last(rx_last),
		.out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind), .tx_byte(tx_byte),
		.run_last(run_last), .status(status), .reg_tag(reg_tag), .value_bits(value_bits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		int          k;
		c = acc ^ {8'h00, b};
		for (k = 0; k < 8; k++) begin
			if (c[0])
				c = {1'b0, c[15:1]} ^ 16'hA001;
			else
				c = {1'b0, c[15:1]};
		end
		return c;
	endfunction

	task automatic advance_master(input req_kind_t kind, input logic [7:0] regn,
			input logic [7:0] b, input logic last);
		logic [7:0]  fr[8];
		logic [15:0] c;
		master_out_t o;
		int          k;
		if (kind == REQ_ISSUE) begin
			fr[0] = slave_addr;
			fr[1] = FUNC_READ;
			fr[2] = 8'h00;
			fr[3] = regn - 8'd1;
			fr[4] = 8'h00;
			fr[5] = REG_COUNT_LO;
			c = 16'hFFFF;
			for (k = 0; k < 6; k++)
				c = crc16_byte(c, fr[k]);
			fr[6] = c[7:0];
			fr[7] = c[15:8];
			for (k = 0; k < 8; k++) begin
				o.kind = KIND_TX;
				o.tx   = fr[k];
				o.last = (k == 7);
				o.st   = ST_OK;
				o.tag  = regn;
				o.val  = '0;
				due_outputs.push_back(o);
			end
			req_open = 1'b1;
			req_reg  = regn;
		end else begin
			rx_crc = crc16_byte(rx_crc, b);
			case (rx_count)
				5'd1: rx_func = b;
				5'd3: rx_word[15:8] = b;
				5'd4: rx_word[7:0] = b;
				5'd5: rx_word[31:24] = b;
				5'd6: rx_word[23:16] = b;
				default: ;
			endcase
			if (rx_count < FRAME_MAX + 1)
				rx_count++;
			if (last) begin
				o.kind = KIND_VERDICT;
				o.tx   = '0;
				o.last = 1'b1;
				o.tag  = req_reg;
				o.val  = '0;
				if (rx_count > FRAME_MAX) begin
					o.st = ST_OVERSIZE;
				end else if (rx_count < 2 || rx_crc != 16'h0000) begin
					o.st = ST_CRC;
				end else begin
					if (rx_count < MIN_FRAME)
						o.st = ST_SHORT;
					else if (rx_func != FUNC_READ)
						o.st = ST_BAD_FUNC;
					else if (!req_open)
						o.st = ST_NONE;
					else begin
						o.st  = ST_OK;
						o.val = rx_word;
					end
					req_open = 1'b0;
				end
				due_outputs.push_back(o);
				rx_crc   = CRC_INIT;
				rx_count = '0;
				rx_func  = '0;
				rx_word  = '0;
			end
		end
	endtask

	// Valid stays up across back-to-back items; this task drops it only when a gap follows.
	task automatic send_item(input req_kind_t kind, input logic [7:0] regn,
			input logic [7:0] b, input logic last);
		repeat (gap_next) @(posedge clk);
		in_valid   <= 1'b1;
		in_held    = 1;
		req_type   <= kind;
		reg_number <= regn;
		rx_byte    <= b;
		rx_last    <= last;
		do @(posedge clk); while (!in_ready);
		advance_master(kind, regn, b, last);
		items_sent++;
		gap_next = calm ? 0 : $urandom_range(0, STALL_MAX);
		if (gap_next != 0) begin
			in_valid <= 1'b0;
			in_held  = 0;
		end
	endtask

	task automatic send_request(input logic [7:0] regn);
		send_item(REQ_ISSUE, regn, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Send frame_buf as one frame, optionally sealed with its CRC, one bit flipped,
	// and a request slipped in before byte req_at.
	task automatic send_frame(input bit seal, input bit flip, input int req_at);
		logic [15:0] c;
		int          k;
		int          n;
		if (seal) begin
			c = CRC_INIT;
			for (k = 0; k < frame_buf.size(); k++)
				c = crc16_byte(c, frame_buf[k]);
			frame_buf.push_back(c[7:0]);
			frame_buf.push_back(c[15:8]);
		end
		n = frame_buf.size();
		if (flip)
			frame_buf[$urandom_range(0, n - 1)] ^= 8'h01 << $urandom_range(0, 7);
		for (k = 0; k < n; k++) begin
			if (k == req_at)
				send_request(8'($urandom_range(0, 255)));
			send_item(REQ_RX, 8'($urandom_range(0, 255)), frame_buf[k], k == n - 1);
		end
		frame_buf.delete();
	endtask

	task automatic stage_reply(input logic [7:0] addr_b, input logic [7:0] fn,
			input logic [31:0] d);
		frame_buf.push_back(addr_b);
		frame_buf.push_back(fn);
		frame_buf.push_back(8'd4);
		frame_buf.push_back(d[31:24]);
		frame_buf.push_back(d[23:16]);
		frame_buf.push_back(d[15:8]);
		frame_buf.push_back(d[7:0]);
	endtask

	task automatic settle();
		if (in_held) begin
			in_valid <= 1'b0;
			in_held  = 0;
		end
		gap_next = 0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slave_address(input logic [7:0] v);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_SLAVE_ADDR;
		pwdata  <= {24'($urandom_range(0, 32'h00FF_FFFF)), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		slave_addr = v;
	endtask

	task automatic test_unsolicited_reply();
		stage_reply(SLAVE_RESET, FUNC_READ, 32'h1234_5678);
		send_frame(1, 0, -1);
	endtask

	task automatic test_request_encoding();
		send_request(8'd0);
		send_request(8'd1);
		send_request(8'd255);
		send_request(8'h80);
	endtask

	task automatic test_reply_verdicts();
		stage_reply(SLAVE_RESET, FUNC_READ, 32'h00FF_55AA);
		send_frame(1, 0, -1);
		// single byte cannot hold a CRC
		send_request(8'd7);
		send_item(REQ_RX, 8'd0, 8'hFF, 1'b1);
		// empty payload sealed: CRC passes, frame too short
		send_frame(1, 0, -1);
		send_request(8'd9);
		frame_buf.push_back(8'hAA);
		frame_buf.push_back(FUNC_READ);
		frame_buf.push_back(8'd4);
		send_frame(1, 0, -1);
		send_request(8'd10);
		stage_reply(SLAVE_RESET, 8'h83, 32'hFFFF_FFFF);
		send_frame(1, 0, -1);
		send_request(8'd11);
		stage_reply(SLAVE_RESET, FUNC_READ, 32'hDEAD_BEEF);
		send_frame(1, 1, -1);
		stage_reply(SLAVE_RESET, FUNC_READ, 32'h0102_0304);
		send_frame(1, 0, -1);
		// request arrives mid-frame, then a second request while pending
		stage_reply(SLAVE_RESET, FUNC_READ, 32'hA5A5_5A5A);
		send_frame(1, 0, 4);
		send_request(8'd20);
		send_request(8'd21);
		stage_reply(SLAVE_RESET, FUNC_READ, 32'h8000_0001);
		send_frame(1, 0, -1);
	endtask

	task automatic test_frame_limits();
		int k;
		send_request(8'd30);
		stage_reply(SLAVE_RESET, FUNC_READ, 32'hCAFE_F00D);
		for (k = 0; k < 7; k++)
			frame_buf.push_back(8'($urandom_range(0, 255)));
		send_frame(1, 0, -1);
		send_request(8'd31);
		stage_reply(SLAVE_RESET, FUNC_READ, 32'h1111_2222);
		for (k = 0; k < 8; k++)
			frame_buf.push_back(8'($urandom_range(0, 255)));
		send_frame(1, 0, -1);
		for (k = 0; k < 30; k++)
			frame_buf.push_back(8'($urandom_range(0, 255)));
		send_frame(0, 0, -1);
		stage_reply(SLAVE_RESET, FUNC_READ, 32'h3333_4444);
		send_frame(1, 0, -1);
	endtask

	task automatic test_slave_address();
		write_slave_address(8'h00);
		send_request(8'd5);
		write_slave_address(8'hFF);
		send_request(8'd6);
		stage_reply(8'hFF, FUNC_READ, 32'h7F80_0000);
		send_frame(1, 0, -1);
		write_slave_address(SLAVE_RESET);
	endtask

	task automatic test_random_traffic(input int count);
		int          stop;
		int          r;
		int          k;
		int          n;
		logic [7:0]  addr_b;
		logic [7:0]  fn;
		stop = items_sent + count;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			addr_b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : slave_addr;
			if (r < 15) begin
				k = $urandom_range(0, 9);
				send_request(k == 0 ? 8'd0 : k == 1 ? 8'd255 : 8'($urandom_range(0, 255)));
			end else if (r < 65) begin
				stage_reply(addr_b, FUNC_READ, $urandom);
				n = frame_buf.size() + 2;
				send_frame(1, 0, ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, n - 1)) : -1);
			end else if (r < 73) begin
				do fn = 8'($urandom_range(0, 255)); while (fn == FUNC_READ);
				stage_reply(addr_b, fn, $urandom);
				send_frame(1, 0, -1);
			end else if (r < 80) begin
				n = $urandom_range(0, 4);
				for (k = 0; k < n; k++)
					frame_buf.push_back(8'($urandom_range(0, 255)));
				send_frame(1, 0, -1);
			end else if (r < 86) begin
				stage_reply(addr_b, FUNC_READ, $urandom);
				n = $urandom_range(5, 9);
				for (k = 0; k < n; k++)
					frame_buf.push_back(8'($urandom_range(0, 255)));
				send_frame(1, 0, -1);
			end else if (r < 94) begin
				stage_reply(addr_b, FUNC_READ, $urandom);
				send_frame(1, 1, -1);
			end else begin
				n = $urandom_range(1, 20);
				for (k = 0; k < n; k++)
					frame_buf.push_back(8'($urandom_range(0, 255)));
				send_frame(0, 0, -1);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_outputs.size() == 0) begin
				mismatches++;
				$display("%0t: output with none expected, expected nothing actual kind %0d tx %0h status %0d",
					$time, out_kind, tx_byte, status);
			end else begin
				got_want = due_outputs.pop_front();
				check_field("out_kind", got_want.kind, out_kind);
				check_field("tx_byte", got_want.tx, tx_byte);
				check_field("run_last", got_want.last, run_last);
				check_field("status", got_want.st, status);
				check_field("reg_tag", got_want.tag, reg_tag);
				check_field("value_bits", got_want.val, value_bits);
			end
		end
	end

	// Receiver: outside calm mode, hold off a random number of cycles before taking each output.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, STALL_MAX);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		req_type   <= 1'b0;
		reg_number <= '0;
		rx_byte    <= '0;
		rx_last    <= 1'b0;
		out_ready  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unsolicited_reply();
		test_request_encoding();
		test_reply_verdicts();
		test_frame_limits();
		test_slave_address();
		write_slave_address(8'($urandom_range(0, 255)));
		test_random_traffic(100);
		write_slave_address(8'h00);
		calm = 1;
		test_random_traffic(100);
		write_slave_address(8'hFF);
		calm = 0;
		test_random_traffic(100);
		settle();
		if (mismatches == 0 && due_outputs.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mbrm_pkg.sv
hw/rtl/mbrm_front.sv
hw/rtl/mbrm_fifo.sv
hw/rtl/mbrm_back.sv
hw/rtl/modbus_rtu_register_read_master.sv
test/tb_modbus_rtu_register_read_master.sv
